// ----- design/option_ack_parser_defines.svh -----
// Assertion macros shared by the option acknowledgement parser.
// Defining ASSERT_OFF leaves every macro body empty.
`ifndef OPTION_ACK_PARSER_DEFINES_SVH
`define OPTION_ACK_PARSER_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked on every rising edge, switched off while reset is high.
`define OAP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define OAP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OAP_ASSERT(label, clk, rst, prop, msg)
`define OAP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- design/oap_pkg.sv -----
// Shared types, keyword constants and helpers for the option acknowledgement parser.
// Used by the front, the command queue, the back and the top level.
package oap_pkg;

   // Result field widths.
   localparam int OPTION_VALUE_W = 32;
   localparam int BLKSIZE_HEADER_BYTES = 4;

   // Command queue geometry (depth is a power of two).
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // Keywords, first character in the top byte, padded with zeros to seven bytes.
   localparam int KW_BYTES = 7;
   localparam int KW_W = KW_BYTES * 8;
   localparam logic [KW_W-1:0] KW_BLKSIZE = "blksize";
   localparam logic [KW_W-1:0] KW_TSIZE = {"tsize", 16'h0000};
   localparam logic [KW_W-1:0] KW_TIMEOUT = "timeout";
   localparam logic [3:0] KW_BLKSIZE_LEN = 4'd7;
   localparam logic [3:0] KW_TSIZE_LEN = 4'd5;
   localparam logic [3:0] KW_TIMEOUT_LEN = 4'd7;

   localparam logic [1:0] HEADER_BYTES = 2'd2;
   localparam logic [3:0] NAME_POS_MAX = 4'd15;
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   typedef enum logic [1:0] {
      KIND_BLKSIZE = 2'd0,
      KIND_TSIZE   = 2'd1,
      KIND_TIMEOUT = 2'd2
   } oap_kind_type;

   // Work handed from the front to the back.
   typedef enum logic [1:0] {
      OP_START,   // a keyword matched: open a new value
      OP_DIGIT,   // a decimal digit of the value
      OP_OTHER    // any other value byte, ends the digit run
   } oap_op_type;

   typedef struct packed {
      oap_op_type   op;
      oap_kind_type kind;
      logic [3:0]   digit;
      logic         emit;
   } oap_cmd_type;

   // True when keyword kw of length len still matches after byte b at position pos.
   function automatic logic kw_keeps(input logic [KW_W-1:0] kw, input logic [3:0] len,
                                     input logic [3:0] pos, input logic [7:0] b);
      logic [KW_W-1:0] shifted;
      logic keep;
      shifted = kw >> {3'(3'd6 - pos[2:0]), 3'b000};
      if (pos < len) begin
         keep = (b == shifted[7:0]);
      end else if (pos == len) begin
         keep = (b == CHAR_NUL);
      end else begin
         keep = 1'b0;
      end
      return keep;
   endfunction

endpackage

// ----- design/oap_front.sv -----
// Front of the parser: accepts datagram bytes, skips the opcode, matches names
// and turns value bytes into commands for the back. Depends on oap_pkg.
module oap_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [7:0]          req_data_byte,
   input  logic                req_end_of_datagram,
   output logic                req_stall,
   input  logic                q_full,
   output logic                q_push,
   output oap_pkg::oap_cmd_type q_cmd
);
   import oap_pkg::*;

   logic [1:0] hdr_ff, hdr_in;
   logic [3:0] pos_ff, pos_in;
   logic [2:0] cand_ff, cand_in;
   logic       expect_ff, expect_in;

   logic        accept;
   logic        cmd_valid;
   logic [2:0]  cand_next;
   logic        is_digit;
   logic [7:0]  digit_byte;

   assign req_stall = q_full;
   assign accept = req_valid && !q_full;
   assign q_push = accept && cmd_valid;

   // Keyword candidates that survive this byte.
   always_comb begin
      cand_next = cand_ff;
      if (!kw_keeps(KW_BLKSIZE, KW_BLKSIZE_LEN, pos_ff, req_data_byte)) cand_next[0] = 1'b0;
      if (!kw_keeps(KW_TSIZE, KW_TSIZE_LEN, pos_ff, req_data_byte)) cand_next[1] = 1'b0;
      if (!kw_keeps(KW_TIMEOUT, KW_TIMEOUT_LEN, pos_ff, req_data_byte)) cand_next[2] = 1'b0;
   end

   assign is_digit = req_data_byte inside {[CHAR_ZERO:CHAR_NINE]};
   assign digit_byte = req_data_byte - CHAR_ZERO;

   // Classify the byte and advance the name tracker.
   always_comb begin
      hdr_in = hdr_ff;
      pos_in = pos_ff;
      cand_in = cand_ff;
      expect_in = expect_ff;
      cmd_valid = 1'b0;
      q_cmd.op = OP_OTHER;
      q_cmd.kind = KIND_BLKSIZE;
      q_cmd.digit = digit_byte[3:0];
      q_cmd.emit = req_end_of_datagram;
      if (hdr_ff < HEADER_BYTES) begin
         hdr_in = hdr_ff + 2'd1;
      end else if (expect_ff) begin
         cmd_valid = 1'b1;
         if (req_data_byte == CHAR_NUL) begin
            q_cmd.emit = 1'b1;
            expect_in = 1'b0;
            pos_in = 4'd0;
            cand_in = 3'b111;
         end else if (is_digit) begin
            q_cmd.op = OP_DIGIT;
         end
      end else begin
         if (req_data_byte == CHAR_NUL) begin
            if (cand_next != 3'b000) begin
               cmd_valid = 1'b1;
               q_cmd.op = OP_START;
               q_cmd.kind = cand_next[0] ? KIND_BLKSIZE :
                            (cand_next[1] ? KIND_TSIZE : KIND_TIMEOUT);
               expect_in = 1'b1;
            end
            pos_in = 4'd0;
            cand_in = 3'b111;
         end else begin
            cand_in = cand_next;
            if (pos_ff < NAME_POS_MAX) pos_in = pos_ff + 4'd1;
         end
      end
      // The last byte of a datagram returns the front to the opcode.
      if (req_end_of_datagram) begin
         hdr_in = 2'd0;
         pos_in = 4'd0;
         cand_in = 3'b111;
         expect_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= 2'd0;
         pos_ff <= 4'd0;
         cand_ff <= 3'b111;
         expect_ff <= 1'b0;
      end else if (accept) begin
         hdr_ff <= hdr_in;
         pos_ff <= pos_in;
         cand_ff <= cand_in;
         expect_ff <= expect_in;
      end
   end

endmodule

// ----- design/oap_queue.sv -----
// Short command queue that decouples the parser front from the value back.
// Depends on oap_pkg for the command type and depth.
module oap_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  oap_pkg::oap_cmd_type push_cmd,
   output logic                full,
   output logic                pop_valid,
   output oap_pkg::oap_cmd_type pop_cmd,
   input  logic                pop
);
   import oap_pkg::*;

   oap_cmd_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + QUEUE_CNT_W'(1);
      else if (pop && !push) count_in = count_ff - QUEUE_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
      end
   end

   // Command storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

// ----- design/oap_back.sv -----
// Back of the parser: accumulates the decimal value, clamps it and registers
// each result beat. Depends on oap_pkg for the command type and constants.
module oap_back #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  oap_pkg::oap_cmd_type q_cmd,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_option_kind,
   output logic [oap_pkg::OPTION_VALUE_W-1:0] rsp_option_value,
   output logic                rsp_value_saturated
);
   import oap_pkg::*;

   localparam int ACC_W = (VALUE_WIDTH >= OPTION_VALUE_W) ? OPTION_VALUE_W : VALUE_WIDTH;
   localparam int SUM_W = ACC_W + 4;
   localparam logic [ACC_W-1:0] CEIL = {ACC_W{1'b1}};

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             ended_ff, ended_in;
   logic             ovf_ff, ovf_in;
   oap_kind_type     kind_ff, kind_in;

   logic                      rsp_valid_ff;
   oap_kind_type              rsp_kind_ff;
   logic [OPTION_VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_sat_ff;

   logic             out_free;
   logic [SUM_W-1:0] mul_sum;
   logic             mul_ovf;
   logic [ACC_W:0]   plus_hdr;
   logic [ACC_W-1:0] emit_value;
   logic             emit_sat;

   // A command that emits waits for the output register to free up.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop = q_valid && (!q_cmd.emit || out_free);

   // Value times ten plus the new digit.
   assign mul_sum = SUM_W'({acc_ff, 3'b000}) + SUM_W'({acc_ff, 1'b0}) + SUM_W'(q_cmd.digit);
   assign mul_ovf = |mul_sum[SUM_W-1:ACC_W];

   always_comb begin
      acc_in = acc_ff;
      ended_in = ended_ff;
      ovf_in = ovf_ff;
      kind_in = kind_ff;
      case (q_cmd.op)
         OP_START: begin
            acc_in = '0;
            ended_in = 1'b0;
            ovf_in = 1'b0;
            kind_in = q_cmd.kind;
         end
         OP_DIGIT: begin
            if (!ended_ff) begin
               acc_in = mul_ovf ? CEIL : mul_sum[ACC_W-1:0];
               ovf_in = ovf_ff | mul_ovf;
            end
         end
         OP_OTHER: begin
            ended_in = 1'b1;
         end
         default: begin
            ended_in = ended_ff;
         end
      endcase
   end

   // Block size results carry the header bytes on top, clamped again.
   assign plus_hdr = {1'b0, acc_in} + (ACC_W + 1)'(BLKSIZE_HEADER_BYTES);
   always_comb begin
      emit_value = acc_in;
      emit_sat = ovf_in;
      if (kind_in == KIND_BLKSIZE) begin
         emit_value = plus_hdr[ACC_W] ? CEIL : plus_hdr[ACC_W-1:0];
         emit_sat = ovf_in | plus_hdr[ACC_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         ended_ff <= 1'b0;
         ovf_ff <= 1'b0;
         kind_ff <= KIND_BLKSIZE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            acc_ff <= acc_in;
            ended_ff <= ended_in;
            ovf_ff <= ovf_in;
            kind_ff <= kind_in;
         end
         if (q_pop && q_cmd.emit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload holds while stalled.
   always_ff @(posedge clock) begin
      if (q_pop && q_cmd.emit) begin
         rsp_kind_ff <= kind_in;
         rsp_value_ff <= OPTION_VALUE_W'(emit_value);
         rsp_sat_ff <= emit_sat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_option_kind = rsp_kind_ff;
   assign rsp_option_value = rsp_value_ff;
   assign rsp_value_saturated = rsp_sat_ff;

endmodule

// ----- design/option_ack_parser.sv -----
// Option acknowledgement parser: one datagram byte per cycle in, one option beat out per value.
// A byte that completes an option goes through the command queue, then the output register.
// Throughput: one byte per cycle; the command queue stalls input only when four commands wait.
// The output register lets a new byte in while a finished beat still waits to be taken.
// Reset is synchronous and clears the parser, the queue and the output valid at once.
// Top level; instantiates oap_front, oap_queue and oap_back, uses oap_pkg and the macros.
`include "option_ack_parser_defines.svh"
module option_ack_parser #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_datagram,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_option_kind,
   output logic [oap_pkg::OPTION_VALUE_W-1:0] rsp_option_value,
   output logic        rsp_value_saturated
);
   import oap_pkg::*;

   localparam int ACC_W = (VALUE_WIDTH >= OPTION_VALUE_W) ? OPTION_VALUE_W : VALUE_WIDTH;

   logic        q_push;
   logic        q_full;
   logic        q_valid;
   logic        q_pop;
   oap_cmd_type push_cmd;
   oap_cmd_type pop_cmd;

   // Byte classification and name matching.
   oap_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_data_byte       (req_data_byte),
      .req_end_of_datagram (req_end_of_datagram),
      .req_stall           (req_stall),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_cmd               (push_cmd)
   );

   // Commands between the two halves.
   oap_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_cmd   (pop_cmd),
      .pop       (q_pop)
   );

   // Value accumulation and result beats.
   oap_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_cmd               (pop_cmd),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_option_kind     (rsp_option_kind),
      .rsp_option_value    (rsp_option_value),
      .rsp_value_saturated (rsp_value_saturated)
   );

   // The queue never takes a command while full.
   `OAP_ASSERT(a_queue_no_overflow, clock, reset, q_push |-> !q_full, "command queue overflow")
   // A new beat only appears after the back took a command.
   `OAP_ASSERT(a_beat_from_pop, clock, reset, $rose(rsp_valid) |-> $past(q_pop), "beat without command")
   // A clamped value is always the ceiling.
   `OAP_ASSERT(a_sat_at_ceiling, clock, reset, (rsp_valid && rsp_value_saturated) |-> (rsp_option_value == OPTION_VALUE_W'({ACC_W{1'b1}})), "saturated value below ceiling")
   // Reset leaves no beat pending.
   `OAP_ASSERT_ALWAYS(a_reset_clears_beat, clock, reset |=> !rsp_valid, "beat valid after reset")

endmodule

// ----- sim/tb_option_ack_parser.sv -----
// Self-checking testbench for option_ack_parser: drives option acknowledgement datagrams
// byte by byte and checks every option beat against a byte-level parser model kept here.
// Depends on oap_pkg for the option kind encoding and on the option_ack_parser RTL.
module tb_option_ack_parser;
   import oap_pkg::*;

   localparam logic [63:0] VALUE_CEIL = 64'h0000_0000_FFFF_FFFF;
   localparam int RANDOM_BYTES = 850;
   localparam int LONG_HOLD = 120;
   localparam int SETTLE_CYCLES = 8;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         wait_drain;
   } dgram_byte_type;

   typedef struct {
      oap_kind_type kind;
      logic [31:0]  value;
      logic         saturated;
   } option_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_datagram = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_option_kind;
   logic [OPTION_VALUE_W-1:0] rsp_option_value;
   logic        rsp_value_saturated;

   // Byte stream waiting to be driven, and option beats still owed by the block.
   dgram_byte_type  byte_queue[$];
   option_beat_type expected_options[$];
   logic [7:0]      dgram[$];

   // Parser state of the model.
   int           opcode_bytes_seen = 0;
   logic [3:0]   name_index = 4'd0;
   logic [2:0]   name_matches = 3'b111;
   bit           reading_value = 1'b0;
   oap_kind_type value_kind = KIND_BLKSIZE;
   logic [63:0]  value_sum = 64'd0;
   bit           digits_done = 1'b0;
   bit           value_clamped = 1'b0;

   // Run statistics and failure count.
   int mismatches = 0;
   int accepted_bytes = 0;
   int checked_options = 0;
   int saturated_options = 0;
   int datagrams_built = 0;
   int input_stall_cycles = 0;
   int output_stall_cycles = 0;
   int idle_cycles = 0;

   option_ack_parser DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_end_of_datagram (req_end_of_datagram),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_option_kind     (rsp_option_kind),
      .rsp_option_value    (rsp_option_value),
      .rsp_value_saturated (rsp_value_saturated)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // Most gaps are absent or short; a few are long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // True when a keyword is still a candidate after byte b at position pos of the name.
   function automatic bit name_survives(input string word, input logic [3:0] pos,
                                        input logic [7:0] b);
      if (pos < word.len()) return b == word[pos];
      if (pos == word.len()) return b == 8'h00;
      return 1'b0;
   endfunction

   task automatic restart_name();
      name_index = 4'd0;
      name_matches = 3'b111;
   endtask

   task automatic clear_parser();
      opcode_bytes_seen = 0;
      restart_name();
      reading_value = 1'b0;
      value_kind = KIND_BLKSIZE;
      value_sum = 64'd0;
      digits_done = 1'b0;
      value_clamped = 1'b0;
   endtask

   // The block size option carries 4 header bytes on top of the parsed value.
   task automatic queue_option();
      option_beat_type beat;
      logic [63:0]     total;
      total = value_sum;
      beat.saturated = value_clamped;
      if (value_kind == KIND_BLKSIZE) begin
         total = total + 64'd4;
         if (total > VALUE_CEIL) begin
            total = VALUE_CEIL;
            beat.saturated = 1'b1;
         end
      end
      beat.kind = value_kind;
      beat.value = total[31:0];
      expected_options.push_back(beat);
   endtask

   // Advances the model by one accepted byte and queues the option it completes, if any.
   task automatic parse_byte(input logic [7:0] b, input logic last);
      logic [2:0] still;
      bit         emitted;
      emitted = 1'b0;
      if (opcode_bytes_seen < 2) begin
         opcode_bytes_seen++;
      end else if (reading_value) begin
         if (b == 8'h00) begin
            queue_option();
            emitted = 1'b1;
            reading_value = 1'b0;
            restart_name();
         end else if (!digits_done && b >= "0" && b <= "9") begin
            value_sum = value_sum * 10 + (b - "0");
            if (value_sum > VALUE_CEIL) begin
               value_sum = VALUE_CEIL;
               value_clamped = 1'b1;
            end
         end else begin
            digits_done = 1'b1;
         end
         if (last && !emitted) queue_option();
      end else begin
         still = name_matches;
         if (!name_survives("blksize", name_index, b)) still[0] = 1'b0;
         if (!name_survives("tsize", name_index, b)) still[1] = 1'b0;
         if (!name_survives("timeout", name_index, b)) still[2] = 1'b0;
         if (b == 8'h00) begin
            if (still != 3'b000) begin
               value_kind = still[0] ? KIND_BLKSIZE : (still[1] ? KIND_TSIZE : KIND_TIMEOUT);
               reading_value = 1'b1;
               value_sum = 64'd0;
               digits_done = 1'b0;
               value_clamped = 1'b0;
            end
            restart_name();
         end else begin
            name_matches = still;
            if (name_index < 4'd15) name_index++;
         end
         if (last && reading_value) queue_option();
      end
      if (last) clear_parser();
   endtask

   // Datagram assembly helpers.
   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) dgram.push_back(s[i]);
   endtask

   task automatic add_nul();
      dgram.push_back(8'h00);
   endtask

   task automatic add_opcode();
      dgram.push_back(8'($urandom_range(0, 255)));
      dgram.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_option(input string name, input string value);
      add_text(name);
      add_nul();
      add_text(value);
      add_nul();
   endtask

   task automatic ship_datagram(input bit hold_for_drain);
      dgram_byte_type item;
      foreach (dgram[i]) begin
         item.data = dgram[i];
         item.last = (i == dgram.size() - 1);
         item.wait_drain = hold_for_drain && (i == 0);
         byte_queue.push_back(item);
      end
      dgram.delete();
      datagrams_built++;
   endtask

   // One name string and one value string with random content, mostly well formed.
   task automatic add_random_option();
      string keywords[3];
      int    pick;
      int    count;
      keywords = '{"blksize", "tsize", "timeout"};
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         add_text(keywords[$urandom_range(0, 2)]);
      end else if (pick == 7) begin
         count = $urandom_range(1, 18);
         repeat (count) dgram.push_back(8'($urandom_range(1, 255)));
      end else if (pick == 8) begin
         // Near misses: a keyword with one byte more, or cut short.
         add_text(keywords[$urandom_range(0, 2)]);
         if ($urandom_range(0, 1) == 0) begin
            dgram.push_back(8'($urandom_range(1, 255)));
         end else begin
            void'(dgram.pop_back());
         end
      end
      add_nul();
      pick = $urandom_range(0, 9);
      if (pick == 1) dgram.push_back(8'($urandom_range(1, 255)));
      count = (pick == 0) ? 0 : ((pick == 2) ? $urandom_range(9, 12) : $urandom_range(1, 5));
      repeat (count) dgram.push_back(8'($urandom_range(8'h30, 8'h39)));
      if ($urandom_range(0, 6) == 0) begin
         count = $urandom_range(1, 4);
         repeat (count) dgram.push_back(8'($urandom_range(1, 255)));
      end
      add_nul();
   endtask

   // Stimulus: directed datagrams, then random ones, then wait for the block to drain.
   initial begin
      int  option_bytes;
      int  count;
      bit  drained_once;

      // Datagrams that end inside the opcode.
      dgram.push_back(8'h00);
      ship_datagram(1'b0);
      add_opcode();
      ship_datagram(1'b0);

      // Every kind, with the smallest and largest values.
      add_opcode();
      add_option("blksize", "512");
      add_option("tsize", "0");
      add_option("timeout", "4294967295");
      ship_datagram(1'b0);

      // Overflow while reading digits, and block size pushed over the ceiling by the header.
      add_opcode();
      add_option("tsize", "99999999999");
      add_option("blksize", "4294967291");
      add_option("blksize", "4294967295");
      ship_datagram(1'b0);

      // Empty names, overlong names, near misses and values that are not pure digits.
      add_opcode();
      add_nul();
      add_option("blksize", "");
      add_option("blksizeblksize", "7");
      repeat (17) dgram.push_back(8'hFF);
      add_nul();
      add_option("timeout", "-5");
      add_option("tsize", " 7");
      add_option("blksize", "12ab34");
      add_option("tsiz", "1");
      add_option("timeouts", "1");
      ship_datagram(1'b0);

      // Datagrams that end right after a name, inside a value, and inside a name.
      add_opcode();
      add_text("timeout");
      add_nul();
      ship_datagram(1'b0);
      add_opcode();
      add_text("tsize");
      add_nul();
      add_text("12");
      ship_datagram(1'b0);
      add_opcode();
      add_text("blksize");
      add_nul();
      add_text("3x");
      ship_datagram(1'b0);
      add_opcode();
      add_text("blksize");
      ship_datagram(1'b0);

      // Random datagrams; a few are plain noise and some are cut off early.
      option_bytes = 0;
      drained_once = 1'b0;
      while (option_bytes < RANDOM_BYTES) begin
         if ($urandom_range(0, 99) < 8) begin
            count = $urandom_range(1, 24);
            repeat (count) dgram.push_back(8'($urandom_range(0, 255)));
            ship_datagram(1'b0);
         end else begin
            add_opcode();
            count = $urandom_range(1, 4);
            repeat (count) add_random_option();
            if ($urandom_range(0, 4) == 0) dgram = dgram[0:$urandom_range(0, dgram.size() - 2)];
            option_bytes += dgram.size();
            ship_datagram(!drained_once && option_bytes > RANDOM_BYTES / 2);
            if (option_bytes > RANDOM_BYTES / 2) drained_once = 1'b1;
         end
      end

      while (byte_queue.size() != 0 || req_valid || expected_options.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Drove %0d bytes in %0d datagrams; checked %0d option beats, %0d saturated.",
               accepted_bytes, datagrams_built, checked_options, saturated_options);
      $display("Input was held off for %0d cycles and the output stalled for %0d cycles.",
               input_stall_cycles, output_stall_cycles);
      if (mismatches == 0) begin
         $display("tb_option_ack_parser: PASS");
      end else begin
         $display("tb_option_ack_parser: FAIL");
      end
      $finish;
   end

   // Byte driver: offers the queued bytes with random gaps between beats.
   always @(posedge clock) begin : drive_bytes
      dgram_byte_type nxt;
      logic           offering;
      int             gap_left;
      int             stretch_left;
      bit             calm;
      if (reset) begin
         req_valid <= 1'b0;
         req_data_byte <= 8'h00;
         req_end_of_datagram <= 1'b0;
         clear_parser();
         gap_left = 0;
         stretch_left = 0;
         calm = 1'b0;
      end else begin
         offering = req_valid;
         if (req_valid && req_stall) input_stall_cycles++;
         if (req_valid && !req_stall) begin
            parse_byte(req_data_byte, req_end_of_datagram);
            accepted_bytes++;
            offering = 1'b0;
            if (stretch_left == 0) begin
               calm = ($urandom_range(0, 2) == 0);
               stretch_left = $urandom_range(30, 120);
            end else begin
               stretch_left--;
            end
         end
         if (!offering) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (byte_queue.size() != 0 &&
                         !(byte_queue[0].wait_drain && expected_options.size() != 0)) begin
               nxt = byte_queue.pop_front();
               req_data_byte <= nxt.data;
               req_end_of_datagram <= nxt.last;
               offering = 1'b1;
               gap_left = calm ? 0 : pick_gap();
            end
         end
         req_valid <= offering;
      end
   end

   // Option monitor: checks each accepted beat and drives the output stall.
   always @(posedge clock) begin : check_options
      option_beat_type want;
      logic            stall_next;
      int              hold_left;
      int              stall_left;
      int              holds_done;
      int              hold_mark;
      int              stretch_left;
      bit              calm;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         stall_left = 0;
         holds_done = 0;
         hold_mark = 300;
         stretch_left = 0;
         calm = 1'b0;
      end else begin
         if (rsp_stall) output_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (expected_options.size() == 0) begin
               $display("%0t: option beat with none expected: kind %0d value %0d saturated %0b",
                        $time, rsp_option_kind, rsp_option_value, rsp_value_saturated);
               mismatches++;
            end else begin
               want = expected_options.pop_front();
               checked_options++;
               if (want.saturated) saturated_options++;
               if (rsp_option_kind !== want.kind) begin
                  $display("%0t: option_kind expected %0d actual %0d",
                           $time, want.kind, rsp_option_kind);
                  mismatches++;
               end
               if (rsp_option_value !== want.value) begin
                  $display("%0t: option_value expected %0d actual %0d",
                           $time, want.value, rsp_option_value);
                  mismatches++;
               end
               if (rsp_value_saturated !== want.saturated) begin
                  $display("%0t: value_saturated expected %0b actual %0b",
                           $time, want.saturated, rsp_value_saturated);
                  mismatches++;
               end
            end
         end

         // Alternate calm stretches with random stalls; twice hold off long enough to fill the block.
         if (stretch_left == 0) begin
            calm = ($urandom_range(0, 2) == 0);
            stretch_left = $urandom_range(40, 160);
         end else begin
            stretch_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (holds_done < 2 && accepted_bytes >= hold_mark) begin
            hold_left = LONG_HOLD - 1;
            holds_done++;
            hold_mark += 500;
            stall_next = 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else begin
            stall_next = 1'b0;
            stall_left = calm ? 0 : pick_gap();
         end
         rsp_stall <= stall_next;
      end
   end

   // Watchdog: ends the run when neither channel has moved a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles, %0d bytes and %0d options pending",
                  $time, idle_cycles, byte_queue.size(), expected_options.size());
         $display("tb_option_ack_parser: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ----- option_ack_parser.f -----
+incdir+design
design/oap_pkg.sv
design/oap_front.sv
design/oap_queue.sv
design/oap_back.sv
design/option_ack_parser.sv
sim/tb_option_ack_parser.sv
